// ===== sv/slid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slid_pkg
// Types, codes and sizing shared by the sorted list cells and top level.
// ----------------------------------------------------------------------------
package slid_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic signed [31:0] data_t;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_DELETED  = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic {
        SL_IDLE,
        SL_BUSY
    } state_t;

    typedef struct packed {
        logic  req_type;
        data_t value;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] entry_count;
        logic [4:0] removed_count;
        data_t      smallest;
        logic       list_empty;
    } rsp_t;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic  ins_en;
        logic  del_en;
        data_t value;
    } cmd_t;

endpackage

// ===== sv/slid_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slid_cell
// One entry of the sorted chain: compares against the request value and
// takes its new value from itself, the request or a neighbor.
// ----------------------------------------------------------------------------
module slid_cell (
    input  logic          aclk,
    input  slid_pkg::cmd_t cmd,
    input  logic          valid,
    input  logic          left_le,
    input  logic          left_shift,
    input  slid_pkg::data_t left_data,
    input  slid_pkg::data_t right_data,
    output slid_pkg::data_t data,
    output logic          le,
    output logic          shift
);
    import slid_pkg::*;

    data_t data_reg;
    data_t data_next;
    logic  eq;

    assign data  = data_reg;
    assign le    = valid && ($signed(data_reg) <= $signed(cmd.value));
    assign eq    = valid && (data_reg == cmd.value);
    // everything from the first match onward moves one place left
    assign shift = eq || left_shift;

    always_comb begin
        data_next = data_reg;
        if (cmd.ins_en) begin
            if (le) begin
                data_next = data_reg;
            end else if (left_le) begin
                data_next = cmd.value;
            end else begin
                data_next = left_data;
            end
        end else if (cmd.del_en && shift) begin
            data_next = right_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

// ===== sv/sorted_list_insert_delete.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_delete
// Ascending sorted list of signed values held in a chain of cells.
// ----------------------------------------------------------------------------
// On an insert every cell compares with the value at once and the cells
// above the insertion point take their left neighbor's entry, so inserts
// stream at one request per cycle while the output register is free. On a
// delete the chain drops the first matching entry each cycle and shifts the
// rest left, finishing on the cycle in which no match remains. A new request
// is taken in the cycle the current one finishes; a result waiting in the
// output register holds off that finish and with it the next request, while
// a delete keeps dropping its matches in the meantime.
module sorted_list_insert_delete (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  slid_pkg::req_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output slid_pkg::rsp_t  m_data
);
    import slid_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    req_t               req_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   removed_reg;
    logic [CNT_W-1:0]   removed_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    rsp_t               m_data_reg;
    rsp_t               m_data_next;

    cmd_t               cmd;
    logic               out_free;
    logic               full;
    logic               match;
    logic               done;
    logic               ins_en;
    logic               del_en;
    logic               accept;

    data_t              cell_data  [CAPACITY];
    logic               cell_le    [CAPACITY];
    logic               cell_shift [CAPACITY];

    logic [CNT_W-1:0]   res_count;
    logic [31:0]        res_count_ext;
    logic [31:0]        res_removed_ext;
    data_t              res_smallest;
    status_t            res_status;

    assign out_free = !m_valid_reg || m_ready;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign match    = cell_shift[CAPACITY-1];
    assign accept   = s_valid && s_ready;

    assign cmd.ins_en = ins_en;
    assign cmd.del_en = del_en;
    assign cmd.value  = req_reg.value;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++) begin : g_cell
            logic  valid_i;
            logic  left_le_i;
            logic  left_shift_i;
            data_t left_data_i;
            data_t right_data_i;

            assign valid_i = (count_reg > CNT_W'(i));

            if (i == 0) begin : g_head
                assign left_le_i    = 1'b1;
                assign left_shift_i = 1'b0;
                assign left_data_i  = req_reg.value;
            end else begin : g_body
                assign left_le_i    = cell_le[i-1];
                assign left_shift_i = cell_shift[i-1];
                assign left_data_i  = cell_data[i-1];
            end

            if (i == CAPACITY - 1) begin : g_tail
                assign right_data_i = '0;
            end else begin : g_mid
                assign right_data_i = cell_data[i+1];
            end

            slid_cell u_cell (
                .aclk       (aclk),
                .cmd        (cmd),
                .valid      (valid_i),
                .left_le    (left_le_i),
                .left_shift (left_shift_i),
                .left_data  (left_data_i),
                .right_data (right_data_i),
                .data       (cell_data[i]),
                .le         (cell_le[i]),
                .shift      (cell_shift[i])
            );
        end
    endgenerate

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SL_IDLE: begin
                if (s_valid) begin
                    state_next = SL_BUSY;
                end
            end
            SL_BUSY: begin
                if (done && !s_valid) begin
                    state_next = SL_IDLE;
                end
            end
            default: state_next = SL_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        done    = 1'b0;
        ins_en  = 1'b0;
        del_en  = 1'b0;
        s_ready = 1'b0;
        unique case (state_reg)
            SL_IDLE: begin
                s_ready = 1'b1;
            end
            SL_BUSY: begin
                if (req_reg.req_type == REQ_INSERT) begin
                    done   = out_free;
                    ins_en = out_free && !full;
                end else begin
                    del_en = match;
                    done   = !match && out_free;
                end
                s_ready = done;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // result of the request finishing this cycle
    always_comb begin
        res_count    = count_reg;
        res_smallest = (count_reg != '0) ? cell_data[0] : '0;
        res_status   = ST_NOTFOUND;
        if (req_reg.req_type == REQ_INSERT) begin
            if (full) begin
                res_status = ST_FULL;
            end else begin
                res_status   = ST_INSERTED;
                res_count    = count_reg + CNT_W'(1);
                res_smallest = cell_le[0] ? cell_data[0] : req_reg.value;
            end
        end else if (removed_reg != '0) begin
            res_status = ST_DELETED;
        end
        res_count_ext   = 32'(res_count);
        res_removed_ext = (req_reg.req_type == REQ_DELETE) ? 32'(removed_reg) : '0;
    end

    always_comb begin
        count_next   = count_reg;
        removed_next = removed_reg;
        if (ins_en) begin
            count_next = count_reg + CNT_W'(1);
        end
        if (del_en) begin
            count_next   = count_reg - CNT_W'(1);
            removed_next = removed_reg + CNT_W'(1);
        end
        if (accept) begin
            removed_next = '0;
        end

        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (done) begin
            m_valid_next              = 1'b1;
            m_data_next.status        = res_status;
            m_data_next.entry_count   = res_count_ext[4:0];
            m_data_next.removed_count = res_removed_ext[4:0];
            m_data_next.smallest      = res_smallest;
            m_data_next.list_empty    = (res_count == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SL_IDLE;
            count_reg   <= '0;
            removed_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            removed_reg <= removed_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_data;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== sv/slid_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slid_checker
// Port-level checks on the sorted list results, bound to the top level.
// ----------------------------------------------------------------------------
module slid_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_valid,
    input logic           m_ready,
    input slid_pkg::rsp_t m_data
);
    import slid_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // inserts never report removed entries
    a_ins_removed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_INSERTED || m_data.status == ST_FULL)
        |-> m_data.removed_count == 5'd0)
        else $error("insert request reported removed entries");

    // delete status agrees with the removed count
    a_del_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_DELETED || m_data.status == ST_NOTFOUND)
        |-> ((m_data.status == ST_DELETED) == (m_data.removed_count != 5'd0)))
        else $error("delete status and removed count disagree");

    // an empty list shows zero as its smallest entry
    a_empty_smallest: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.list_empty |-> m_data.smallest == '0)
        else $error("empty list with nonzero smallest entry");

endmodule

bind sorted_list_insert_delete slid_checker u_slid_checker (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for sorted_list_insert_delete
// Sends insert and delete requests over the input channel and keeps its own
// sorted list to work out each response. Responses are compared field by
// field in arrival order. Random idle bursts, a long output hold-off and a
// drain pause exercise the handshakes.
// ----------------------------------------------------------------------------
module testbench;
    import slid_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int POOL_N         = 8;
    localparam int LONG_HOLD      = 120;
    localparam int SETTLE_CYCLES  = 40;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;

    // shadow copy of the list contents, advanced on every accepted request
    data_t       list_q [CAPACITY];
    int unsigned list_len = 0;
    rsp_t        list_results_due [$];

    data_t value_pool [POOL_N];
    bit    src_idle_on  = 1'b1;
    bit    sink_idle_on = 1'b1;
    int    hold_request = 0;
    int    mismatch_count = 0;
    int    quiet_cycles = 0;

    sorted_list_insert_delete i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    function automatic rsp_t update_sorted_list(input req_t r);
        rsp_t        rsp;
        int unsigned pos;
        int unsigned i;
        int unsigned wr;
        int unsigned removed;
        data_t       v;
        rsp     = '0;
        removed = 0;
        v       = $signed(r.value);
        if (r.req_type == REQ_INSERT) begin
            if (list_len >= CAPACITY) begin
                rsp.status = ST_FULL;
            end else begin
                // new value goes after any equal entries
                pos = 0;
                while (pos < list_len && $signed(list_q[pos]) <= v) pos++;
                for (i = list_len; i > pos; i--) list_q[i] = list_q[i - 1];
                list_q[pos] = v;
                list_len++;
                rsp.status = ST_INSERTED;
            end
        end else begin
            wr = 0;
            for (i = 0; i < list_len; i++) begin
                if (list_q[i] != v) begin
                    list_q[wr] = list_q[i];
                    wr++;
                end
            end
            removed    = list_len - wr;
            list_len   = wr;
            rsp.status = (removed != 0) ? ST_DELETED : ST_NOTFOUND;
        end
        rsp.entry_count   = list_len[4:0];
        rsp.removed_count = removed[4:0];
        rsp.smallest      = (list_len != 0) ? list_q[0] : '0;
        rsp.list_empty    = (list_len == 0);
        return rsp;
    endfunction

    function automatic req_t make_random_request(input int unsigned insert_pct);
        req_t        r;
        int unsigned pick;
        r.req_type = ($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_DELETE;
        pick = $urandom_range(9);
        // deletes mostly target a value that is held, so matches are common
        if (r.req_type == REQ_DELETE && list_len != 0 && pick < 7)
            r.value = list_q[$urandom_range(list_len - 1)];
        else if (pick < 6)
            r.value = value_pool[$urandom_range(POOL_N - 1)];
        else if (pick < 8)
            r.value = $urandom;
        else if (pick == 8)
            r.value = 32'sh8000_0000;
        else
            r.value = 32'sh7fff_ffff;
        return r;
    endfunction

    task automatic refresh_value_pool();
        int k;
        for (k = 0; k < POOL_N; k++) begin
            if (k < POOL_N / 2) value_pool[k] = data_t'(int'($urandom_range(6)) - 3);
            else                value_pool[k] = $urandom;
        end
    endtask

    task automatic send_request(input req_t r);
        int gap;
        if (src_idle_on && $urandom_range(3) == 0) begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        list_results_due.push_back(update_sorted_list(r));
    endtask

    task automatic send_op(input logic kind, input data_t v);
        req_t r;
        r.req_type = kind;
        r.value    = v;
        send_request(r);
    endtask

    // stop offering and wait until every response is back
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (list_results_due.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed_edges();
        send_op(REQ_DELETE, 32'sd0);            // delete on empty list
        send_op(REQ_INSERT, 32'sh7fff_ffff);
        send_op(REQ_INSERT, 32'sh8000_0000);
        send_op(REQ_INSERT, 32'sd0);
        send_op(REQ_DELETE, 32'sh8000_0000);
        send_op(REQ_DELETE, 32'sd12345);        // no match
        send_op(REQ_DELETE, 32'sh7fff_ffff);
        send_op(REQ_DELETE, 32'sd0);
    endtask

    task automatic test_full_store();
        int k;
        for (k = 0; k < CAPACITY; k++)
            send_op(REQ_INSERT, (k % 2 == 0) ? 32'sd9 : -32'sd5);
        send_op(REQ_INSERT, -32'sd100);         // refused, store full
        send_op(REQ_DELETE, -32'sd5);
        send_op(REQ_DELETE, 32'sd9);
    endtask

    task automatic test_random_mix();
        int chunk;
        int k;
        for (chunk = 0; chunk < 12; chunk++) begin
            refresh_value_pool();
            src_idle_on  = (chunk % 3 != 2);
            sink_idle_on = (chunk % 4 != 3);
            // alternate growing and shrinking phases to walk between empty and full
            for (k = 0; k < 100; k++)
                send_request(make_random_request((chunk % 2 == 0) ? 75 : 30));
        end
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        int k;
        hold_request = LONG_HOLD;
        for (k = 0; k < 30; k++) send_request(make_random_request(60));
    endtask

    task automatic test_drain_pause();
        int k;
        wait_results_drained();
        for (k = 0; k < 50; k++) send_request(make_random_request(50));
    endtask

    task automatic test_back_to_back();
        int k;
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        refresh_value_pool();
        for (k = 0; k < 300; k++)
            send_request(make_random_request((k / 50) % 2 == 0 ? 70 : 35));
    endtask

    // result sink with random stall bursts and an optional long hold-off
    initial begin : result_sink
        int n;
        wait (aresetn);
        forever begin
            if (hold_request > 0) begin
                n = hold_request;
                hold_request = 0;
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else if (sink_idle_on && $urandom_range(4) == 0) begin
                n = $urandom_range(1, 6);
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (list_results_due.size() == 0) begin
                $error("response with none outstanding: %p", m_data);
                mismatch_count++;
            end else begin
                want = list_results_due.pop_front();
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_data.status);
                    mismatch_count++;
                end
                if (m_data.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, m_data.entry_count);
                    mismatch_count++;
                end
                if (m_data.removed_count !== want.removed_count) begin
                    $error("removed_count: expected %0d, got %0d",
                           want.removed_count, m_data.removed_count);
                    mismatch_count++;
                end
                if (m_data.smallest !== want.smallest) begin
                    $error("smallest: expected %0d, got %0d",
                           $signed(want.smallest), $signed(m_data.smallest));
                    mismatch_count++;
                end
                if (m_data.list_empty !== want.list_empty) begin
                    $error("list_empty: expected %0d, got %0d",
                           want.list_empty, m_data.list_empty);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("FAIL sorted_list_insert_delete");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_edges();
        test_full_store();
        test_random_mix();
        test_output_backpressure();
        test_drain_pause();
        test_back_to_back();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && list_results_due.size() == 0) begin
            $display("PASS sorted_list_insert_delete");
        end else begin
            $display("FAIL sorted_list_insert_delete");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/slid_pkg.sv
sv/slid_cell.sv
sv/sorted_list_insert_delete.sv
sv/slid_checker.sv
dv/testbench.sv
